// File: sv/mlp221_pkg.sv
// Shared types, constants and arithmetic helpers for the 2-2-1 perceptron.
// The sigmoid table is built here at elaboration time from integer arithmetic.
// No dependencies.
package mlp221_pkg;

	localparam int FRAC_BITS = 12;
	localparam int TAB_DEPTH = 256;
	localparam int TAB_LOG2  = $clog2(TAB_DEPTH);
	// Bits of the Q.(2F) sum below one table segment.
	localparam int SEG_SH    = 2 * FRAC_BITS + 4 - TAB_LOG2;

	typedef logic [12:0]        act_t;
	typedef logic [12:0]        lr_t;
	typedef logic signed [15:0] wt_t;
	typedef logic signed [13:0] eo_t;
	typedef logic signed [14:0] go_t;
	typedef logic signed [31:0] prod_t;
	typedef logic signed [32:0] z_t;
	typedef logic signed [47:0] wide_t;

	typedef struct packed {
		logic       operation;
		wt_t        input_a;
		wt_t        input_b;
		act_t       target;
	} item_t;

	typedef struct packed {
		act_t net_output;
		act_t hidden_a;
		act_t hidden_b;
	} result_t;

	typedef struct packed {
		logic mul_h;
		logic sum_h;
		logic sig_h;
		logic mul_o;
		logic sum_o;
		logic sig_o;
		logic dy;
		logic eo;
		logic back;
		logic upd_o;
		logic grad_h;
		logic upd_h;
	} ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL_H, ST_SUM_H, ST_SIG_H, ST_MUL_O, ST_SUM_O, ST_SIG_O,
		ST_EMIT, ST_DY, ST_EO, ST_BACK, ST_UPD_O, ST_GRAD_H, ST_UPD_H
	} state_t;

	typedef act_t sig_tab_t [TAB_DEPTH+1];

	localparam logic signed [13:0] ONE_S = 14'(1 << FRAC_BITS);
	localparam logic signed [33:0] SIG_OFFSET = 34'(64'd8 << (2 * FRAC_BITS));

	function automatic int from_h(int h);
		return ((h << FRAC_BITS) + 50) / 100;
	endfunction

	localparam wt_t WH_RST [4] = '{wt_t'(from_h(15)), wt_t'(from_h(25)),
		wt_t'(from_h(20)), wt_t'(from_h(30))};
	localparam wt_t WO_RST [2] = '{wt_t'(from_h(40)), wt_t'(from_h(50))};
	localparam lr_t LR_RST = lr_t'(from_h(10));

	// Restoring long division, used only while the table is built.
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int k = 63; k >= 0; k--) begin
			r = {r[63:0], n[k]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[k] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic sig_tab_t build_sig_tab();
		logic [63:0] one, step, term, ratio, e, den, pos;
		logic signed [63:0] sum;
		sig_tab_t t;
		one  = 64'd1 << 32;
		step = (64'd8 << 32) >> TAB_LOG2;
		term = one;
		sum  = $signed(one);
		for (int n = 1; n <= 12; n++) begin
			term = udiv64((term * step) >> 32, 64'(n));
			if ((n & 1) == 1) sum = sum - $signed(term);
			else sum = sum + $signed(term);
		end
		ratio = sum;
		e = one;
		for (int m = 0; m <= TAB_DEPTH; m++) begin
			if (((TAB_DEPTH + m) & 1) == 0) begin
				den = one + e;
				pos = udiv64((64'd1 << (FRAC_BITS + 32)) + (den >> 1), den);
				t[(TAB_DEPTH + m) >> 1] = act_t'(pos);
				t[(TAB_DEPTH - m) >> 1] = act_t'((64'd1 << FRAC_BITS) - pos);
			end
			e = (e * ratio + (one >> 1)) >> 32;
		end
		return t;
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig_tab();

	// Shift right by FRAC_BITS, rounding to nearest with ties away from zero.
	function automatic wide_t rnd(wide_t v);
		wide_t mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (48'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic wt_t sat16(wide_t v);
		if (v > 48'sd32767) return 16'sh7FFF;
		if (v < -48'sd32768) return 16'sh8000;
		return wt_t'(v);
	endfunction

	// Table sigmoid of a Q.(2F) sum with linear interpolation.
	function automatic act_t sigmoid(z_t z);
		logic signed [33:0] p;
		logic [33:0] idx;
		logic [TAB_LOG2:0] ia, ib;
		logic [SEG_SH-1:0] rem;
		act_t a, b, r;
		logic [47:0] acc;
		p = 34'(z) + SIG_OFFSET;
		idx = '0;
		ia = '0;
		ib = '0;
		rem = '0;
		a = '0;
		b = '0;
		acc = '0;
		if (p < 0) begin
			r = SIG_TAB[0];
		end else begin
			idx = 34'(p >>> SEG_SH);
			if (idx >= 34'(TAB_DEPTH)) begin
				r = SIG_TAB[TAB_DEPTH];
			end else begin
				ia = idx[TAB_LOG2:0];
				ib = ia + 1'b1;
				a = SIG_TAB[ia];
				b = SIG_TAB[ib];
				rem = p[SEG_SH-1:0];
				acc = 48'(b - a) * 48'(rem) + (48'd1 << (SEG_SH - 1));
				r = a + act_t'(acc >> SEG_SH);
			end
		end
		return r;
	endfunction

endpackage

// File: sv/mlp_221_online_backprop_unit.sv
// Top level of the 2-2-1 sigmoid perceptron with online training.
// Depends on mlp221_pkg, mlp221_lane and mlp221_merge.
//
// Usage: an item beat on the item channel carries two Q4.12 inputs, a Q1.12
// target and an operation (infer or train). The block takes one item at a time
// and holds item_stall high until it is back in its idle state. Each item gives
// exactly one result beat with the output activation and both hidden
// activations, all computed with the weights as they stood before the item.
// The result is registered in the emit step, after the hidden and then the output
// multiply, sum and sigmoid steps. An inference item occupies the block up to the emit
// step, a training item until its updates are done; the sequencer steps both hidden lanes
// and the output neuron through multiply, sum, sigmoid, delta and update in turn.
// The learning rate is written on the cfg channel; cfg_ready is high only while
// the block is idle.
// Reset clears the sequencer and the result valid flag, restores the six weights
// to their initial values and the learning rate to about 0.1.
// When the receiver stalls, the finished result waits in the output register;
// the next item is still accepted and only blocks once its own result is ready.
module mlp_221_online_backprop_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  mlp221_pkg::item_t    item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output mlp221_pkg::result_t  result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  mlp221_pkg::lr_t      cfg_data
);
	import mlp221_pkg::*;

	state_t  state_q, state_d;
	ctrl_t   ctrl;
	lr_t     lr_q;
	wt_t     x_a_q, x_b_q;
	act_t    target_q;
	logic    train_q;
	logic    result_valid_q;
	result_t result_q;
	logic    space;
	act_t    h_a, h_b, y;
	prod_t   po_a, po_b;
	eo_t     eo;
	go_t     go;

	// The output register has room when it is empty or being emptied this cycle.
	assign space      = !result_valid_q || !result_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign cfg_ready  = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		unique case (state_q)
			ST_IDLE:   if (item_valid) state_d = ST_MUL_H;
			ST_MUL_H:  begin ctrl.mul_h = 1'b1; state_d = ST_SUM_H; end
			ST_SUM_H:  begin ctrl.sum_h = 1'b1; state_d = ST_SIG_H; end
			ST_SIG_H:  begin ctrl.sig_h = 1'b1; state_d = ST_MUL_O; end
			ST_MUL_O:  begin ctrl.mul_o = 1'b1; state_d = ST_SUM_O; end
			ST_SUM_O:  begin ctrl.sum_o = 1'b1; state_d = ST_SIG_O; end
			ST_SIG_O:  begin ctrl.sig_o = 1'b1; state_d = ST_EMIT; end
			ST_EMIT: begin
				if (space) state_d = train_q ? ST_DY : ST_IDLE;
			end
			ST_DY:     begin ctrl.dy = 1'b1; state_d = ST_EO; end
			ST_EO:     begin ctrl.eo = 1'b1; state_d = ST_BACK; end
			ST_BACK:   begin ctrl.back = 1'b1; state_d = ST_UPD_O; end
			ST_UPD_O:  begin ctrl.upd_o = 1'b1; state_d = ST_GRAD_H; end
			ST_GRAD_H: begin ctrl.grad_h = 1'b1; state_d = ST_UPD_H; end
			ST_UPD_H:  begin ctrl.upd_h = 1'b1; state_d = ST_IDLE; end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Learning rate register, written only while idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= LR_RST;
		end else if (cfg_valid && cfg_ready) begin
			lr_q <= cfg_data;
		end
	end

	// Capture the accepted item; the lanes read it throughout the step.
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			x_a_q    <= item.input_a;
			x_b_q    <= item.input_b;
			target_q <= item.target;
			train_q  <= item.operation;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && space) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && space) begin
			result_q.net_output <= y;
			result_q.hidden_a   <= h_a;
			result_q.hidden_b   <= h_b;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	mlp221_lane #(.LANE(0)) u_lane_a (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .x_a(x_a_q), .x_b(x_b_q),
		.eo(eo), .go(go), .lr(lr_q), .h(h_a), .po(po_a)
	);

	mlp221_lane #(.LANE(1)) u_lane_b (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .x_a(x_a_q), .x_b(x_b_q),
		.eo(eo), .go(go), .lr(lr_q), .h(h_b), .po(po_b)
	);

	mlp221_merge u_merge (
		.clk(clk), .ctrl(ctrl), .po_a(po_a), .po_b(po_b), .target(target_q),
		.lr(lr_q), .y(y), .eo(eo), .go(go)
	);

	// An accepted item always starts the forward pass.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> (state_q == ST_MUL_H))
		else $error("accepted item did not start the forward pass");

	// A new result only appears from the emit step.
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_EMIT))
		else $error("result appeared outside the emit step");

	// A full, stalled output register holds the sequencer in the emit step.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && result_valid && result_stall) |=>
		(state_q == ST_EMIT && result_valid))
		else $error("result overwritten while stalled");

	// Weight updates only follow a training item.
	a_train: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DY) |-> train_q)
		else $error("update sequence entered for an inference item");

endmodule

// File: sv/mlp221_lane.sv
// One hidden neuron lane: its three weights, forward pass and its share of the update.
// Depends on mlp221_pkg.
module mlp221_lane #(
	parameter int unsigned LANE = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mlp221_pkg::ctrl_t  ctrl,
	input  mlp221_pkg::wt_t    x_a,
	input  mlp221_pkg::wt_t    x_b,
	input  mlp221_pkg::eo_t    eo,
	input  mlp221_pkg::go_t    go,
	input  mlp221_pkg::lr_t    lr,
	output mlp221_pkg::act_t   h,
	output mlp221_pkg::prod_t  po
);
	import mlp221_pkg::*;

	wt_t   wh0_q, wh1_q, wo_q;
	prod_t p0_q, p1_q, po_q;
	z_t    z_q;
	act_t  h_q;
	logic signed [11:0] dh_q;
	logic signed [16:0] a_q;
	logic signed [14:0] eh_q;
	logic signed [15:0] gh_q;
	logic signed [13:0] h_s;
	wide_t pa, pb, po_w, dh_w, a_w, eh_w, duo_w, gh_w, dwa_w, dwb_w;

	always_comb begin
		h_s   = $signed({1'b0, h_q});
		pa    = x_a * wh0_q;
		pb    = x_b * wh1_q;
		po_w  = h_s * wo_q;
		dh_w  = h_s * (ONE_S - h_s);
		a_w   = eo * wo_q;
		eh_w  = a_q * dh_q;
		duo_w = go * h_s;
		gh_w  = $signed({1'b0, lr}) * eh_q;
		dwa_w = gh_q * x_a;
		dwb_w = gh_q * x_b;
	end

	// The weights are state and return to their initial values at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wh0_q <= WH_RST[LANE];
			wh1_q <= WH_RST[2 + LANE];
			wo_q  <= WO_RST[LANE];
		end else begin
			if (ctrl.upd_o) wo_q <= sat16(48'(wo_q) + rnd(duo_w));
			if (ctrl.upd_h) begin
				wh0_q <= sat16(48'(wh0_q) + rnd(dwa_w));
				wh1_q <= sat16(48'(wh1_q) + rnd(dwb_w));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_h) begin
			p0_q <= 32'(pa);
			p1_q <= 32'(pb);
		end
		if (ctrl.sum_h) z_q <= 33'(p0_q) + 33'(p1_q);
		if (ctrl.sig_h) h_q <= sigmoid(z_q);
		if (ctrl.mul_o) begin
			po_q <= 32'(po_w);
			dh_q <= 12'(rnd(dh_w));
		end
		if (ctrl.back)   a_q  <= 17'(rnd(a_w));
		if (ctrl.upd_o)  eh_q <= 15'(rnd(eh_w));
		if (ctrl.grad_h) gh_q <= 16'(rnd(gh_w));
	end

	assign h  = h_q;
	assign po = po_q;

endmodule

// File: sv/mlp221_merge.sv
// Output neuron: merges the two lane products, then forms the output error and gradient.
// Depends on mlp221_pkg.
module mlp221_merge (
	input  logic               clk,
	input  mlp221_pkg::ctrl_t  ctrl,
	input  mlp221_pkg::prod_t  po_a,
	input  mlp221_pkg::prod_t  po_b,
	input  mlp221_pkg::act_t   target,
	input  mlp221_pkg::lr_t    lr,
	output mlp221_pkg::act_t   y,
	output mlp221_pkg::eo_t    eo,
	output mlp221_pkg::go_t    go
);
	import mlp221_pkg::*;

	z_t   zo_q;
	act_t y_q;
	logic signed [11:0] dy_q;
	eo_t  eo_q;
	go_t  go_q;
	logic signed [13:0] y_s;
	wide_t dy_w, eo_w, go_w;

	always_comb begin
		y_s  = $signed({1'b0, y_q});
		dy_w = y_s * (ONE_S - y_s);
		eo_w = ($signed({1'b0, target}) - y_s) * dy_q;
		go_w = $signed({1'b0, lr}) * eo_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.sum_o) zo_q <= 33'(po_a) + 33'(po_b);
		if (ctrl.sig_o) y_q  <= sigmoid(zo_q);
		if (ctrl.dy)    dy_q <= 12'(rnd(dy_w));
		if (ctrl.eo)    eo_q <= 14'(rnd(eo_w));
		if (ctrl.back)  go_q <= 15'(rnd(go_w));
	end

	assign y  = y_q;
	assign eo = eo_q;
	assign go = go_q;

endmodule
